// File: rtl/qvr_pkg.sv
// Shared types, widths and codes for the quaternion vector rotation core.
package qvr_pkg;

    localparam int QUAT_FRAC_BITS_DEF = 14;
    localparam int TOL_FRAC_BITS      = 28;

    localparam int COMP_W  = 16;
    localparam int TOL_W   = 20;
    localparam int IDX_W   = 3;
    localparam int MAG_W   = 50;
    localparam int DIV_W   = MAG_W + 1;
    localparam int QUO_W   = 17;
    localparam int STAT_W  = 2;

    localparam logic [IDX_W-1:0] REG_QUAT_X = 3'd0;
    localparam logic [IDX_W-1:0] REG_QUAT_Y = 3'd1;
    localparam logic [IDX_W-1:0] REG_QUAT_Z = 3'd2;
    localparam logic [IDX_W-1:0] REG_QUAT_W = 3'd3;
    localparam logic [IDX_W-1:0] REG_TOL    = 3'd4;

    localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
    localparam logic [STAT_W-1:0] STAT_SAT  = 2'd1;
    localparam logic [STAT_W-1:0] STAT_ZERO = 2'd2;

    // One lane of the divider pipeline: magnitude of a rotated component.
    typedef struct packed {
        logic             valid;
        logic             neg;
        logic             zero;
        logic             ovf;
        logic [MAG_W-1:0] rem;
        logic [DIV_W-1:0] d;
        logic [QUO_W-1:0] q;
    } div_item_t;

endpackage

// File: rtl/quaternion_vector_rotate_core.sv
// Top level: configuration registers, product and divider pipelines, output stage.
// Rotates one vector per clock by the configured quaternion, q*v*conj(q), divided
// by |q|^2 (or by the Q scale when |q|^2 is within unit_tolerance of one),
// truncated toward zero and saturated to 16 bits. Throughput is one item per cycle;
// each accepted item passes four stages of products and sums, eighteen divider
// stages (overflow detect, then one quotient bit each) and the output register
// before m_valid. A stall on m_ready holds the whole pipeline. The registers are
// read in the first and third stages, so write configuration only while no item
// is in flight.
module quaternion_vector_rotate_core #(
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              cfg_we,
    input  logic [qvr_pkg::IDX_W-1:0]         cfg_index,
    input  logic [qvr_pkg::TOL_W-1:0]         cfg_wdata,
    input  logic                              s_valid,
    output logic                              s_ready,
    input  logic signed [qvr_pkg::COMP_W-1:0] s_vec_x,
    input  logic signed [qvr_pkg::COMP_W-1:0] s_vec_y,
    input  logic signed [qvr_pkg::COMP_W-1:0] s_vec_z,
    output logic                              m_valid,
    input  logic                              m_ready,
    output logic signed [qvr_pkg::COMP_W-1:0] m_rot_x,
    output logic signed [qvr_pkg::COMP_W-1:0] m_rot_y,
    output logic signed [qvr_pkg::COMP_W-1:0] m_rot_z,
    output logic [qvr_pkg::STAT_W-1:0]        m_status
);

    logic signed [qvr_pkg::COMP_W-1:0] qx_reg, qy_reg, qz_reg, qw_reg;
    logic [qvr_pkg::TOL_W-1:0]         tol_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            qx_reg  <= '0;
            qy_reg  <= '0;
            qz_reg  <= '0;
            qw_reg  <= 16'sd16384;
            tol_reg <= 20'd32;
        end else if (cfg_we) begin
            case (cfg_index)
                qvr_pkg::REG_QUAT_X: qx_reg  <= cfg_wdata[qvr_pkg::COMP_W-1:0];
                qvr_pkg::REG_QUAT_Y: qy_reg  <= cfg_wdata[qvr_pkg::COMP_W-1:0];
                qvr_pkg::REG_QUAT_Z: qz_reg  <= cfg_wdata[qvr_pkg::COMP_W-1:0];
                qvr_pkg::REG_QUAT_W: qw_reg  <= cfg_wdata[qvr_pkg::COMP_W-1:0];
                qvr_pkg::REG_TOL:    tol_reg <= cfg_wdata;
                default: ;
            endcase
        end
    end

    logic adv;
    logic m_valid_reg;
    assign adv     = !m_valid_reg || m_ready;
    assign s_ready = adv;

    qvr_pkg::div_item_t px, py, pz, dx, dy, dz;

    qvr_product #(.QUAT_FRAC_BITS(QUAT_FRAC_BITS)) u_product (
        .aclk(aclk), .aresetn(aresetn), .adv(adv), .in_valid(s_valid),
        .vx(s_vec_x), .vy(s_vec_y), .vz(s_vec_z),
        .ax(qx_reg), .ay(qy_reg), .az(qz_reg), .aw(qw_reg), .tol(tol_reg),
        .out_x(px), .out_y(py), .out_z(pz)
    );

    qvr_divider u_div_x (.aclk(aclk), .aresetn(aresetn), .adv(adv), .in_item(px), .out_item(dx));
    qvr_divider u_div_y (.aclk(aclk), .aresetn(aresetn), .adv(adv), .in_item(py), .out_item(dy));
    qvr_divider u_div_z (.aclk(aclk), .aresetn(aresetn), .adv(adv), .in_item(pz), .out_item(dz));

    function automatic logic [qvr_pkg::COMP_W:0] finish(qvr_pkg::div_item_t it);
        logic [qvr_pkg::COMP_W-1:0] v;
        logic                       s;
        v = qvr_pkg::COMP_W'(it.q);
        s = 1'b0;
        if (it.neg) begin
            if (it.ovf || it.q > qvr_pkg::QUO_W'(32768)) begin
                v = 16'h8000;
                s = 1'b1;
            end else begin
                v = qvr_pkg::COMP_W'(-it.q);
            end
        end else if (it.ovf || it.q > qvr_pkg::QUO_W'(32767)) begin
            v = 16'h7FFF;
            s = 1'b1;
        end
        return {s, v};
    endfunction

    logic [qvr_pkg::COMP_W:0] fx, fy, fz;
    logic signed [qvr_pkg::COMP_W-1:0] rx_reg, ry_reg, rz_reg;
    logic [qvr_pkg::STAT_W-1:0] stat_reg;

    assign fx = finish(dx);
    assign fy = finish(dy);
    assign fz = finish(dz);

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (adv) begin
            m_valid_reg <= dx.valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            if (dx.zero) begin
                rx_reg   <= '0;
                ry_reg   <= '0;
                rz_reg   <= '0;
                stat_reg <= qvr_pkg::STAT_ZERO;
            end else begin
                rx_reg   <= fx[qvr_pkg::COMP_W-1:0];
                ry_reg   <= fy[qvr_pkg::COMP_W-1:0];
                rz_reg   <= fz[qvr_pkg::COMP_W-1:0];
                stat_reg <= (fx[qvr_pkg::COMP_W] || fy[qvr_pkg::COMP_W] || fz[qvr_pkg::COMP_W])
                          ? qvr_pkg::STAT_SAT : qvr_pkg::STAT_OK;
            end
        end
    end

    assign m_valid  = m_valid_reg;
    assign m_rot_x  = rx_reg;
    assign m_rot_y  = ry_reg;
    assign m_rot_z  = rz_reg;
    assign m_status = stat_reg;

endmodule

// File: rtl/qvr_product.sv
// Four-stage pipeline forming q*v*conj(q), |q|^2 and the divisor.
module qvr_product #(
    parameter int QUAT_FRAC_BITS = qvr_pkg::QUAT_FRAC_BITS_DEF
) (
    input  logic                             aclk,
    input  logic                             aresetn,
    input  logic                             adv,
    input  logic                             in_valid,
    input  logic signed [qvr_pkg::COMP_W-1:0] vx,
    input  logic signed [qvr_pkg::COMP_W-1:0] vy,
    input  logic signed [qvr_pkg::COMP_W-1:0] vz,
    input  logic signed [qvr_pkg::COMP_W-1:0] ax,
    input  logic signed [qvr_pkg::COMP_W-1:0] ay,
    input  logic signed [qvr_pkg::COMP_W-1:0] az,
    input  logic signed [qvr_pkg::COMP_W-1:0] aw,
    input  logic        [qvr_pkg::TOL_W-1:0]  tol,
    output qvr_pkg::div_item_t               out_x,
    output qvr_pkg::div_item_t               out_y,
    output qvr_pkg::div_item_t               out_z
);

    localparam int TWO_F  = 2 * QUAT_FRAC_BITS;
    localparam int DFW    = ((TWO_F + 1 > 34) ? TWO_F + 1 : 34) + 1;
    localparam int CMPW   = DFW + qvr_pkg::TOL_FRAC_BITS + qvr_pkg::TOL_W;
    localparam int LSH    = (TWO_F >= qvr_pkg::TOL_FRAC_BITS) ? 0 : qvr_pkg::TOL_FRAC_BITS - TWO_F;
    localparam int RSH    = (TWO_F >= qvr_pkg::TOL_FRAC_BITS) ? TWO_F - qvr_pkg::TOL_FRAC_BITS : 0;

    // stage 1: first-level products
    logic               v1_reg;
    logic signed [31:0] xx1_reg, xy1_reg, xz1_reg, yx1_reg, yy1_reg, yz1_reg;
    logic signed [31:0] zx1_reg, zy1_reg, zz1_reg, wx1_reg, wy1_reg, wz1_reg;
    logic signed [31:0] sx1_reg, sy1_reg, sz1_reg, sw1_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            xx1_reg <= ax * vx;  xy1_reg <= ax * vy;  xz1_reg <= ax * vz;
            yx1_reg <= ay * vx;  yy1_reg <= ay * vy;  yz1_reg <= ay * vz;
            zx1_reg <= az * vx;  zy1_reg <= az * vy;  zz1_reg <= az * vz;
            wx1_reg <= aw * vx;  wy1_reg <= aw * vy;  wz1_reg <= aw * vz;
            sx1_reg <= ax * ax;  sy1_reg <= ay * ay;
            sz1_reg <= az * az;  sw1_reg <= aw * aw;
        end
    end

    // stage 2: p = q * (v, 0) and |q|^2
    logic               v2_reg;
    logic signed [33:0] ps2_reg, px2_reg, py2_reg, pz2_reg;
    logic        [33:0] m2_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v2_reg <= 1'b0;
        end else if (adv) begin
            v2_reg <= v1_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            ps2_reg <= -(34'(xx1_reg) + 34'(yy1_reg) + 34'(zz1_reg));
            px2_reg <= 34'(wx1_reg) + 34'(yz1_reg) - 34'(zy1_reg);
            py2_reg <= 34'(wy1_reg) + 34'(zx1_reg) - 34'(xz1_reg);
            pz2_reg <= 34'(wz1_reg) + 34'(xy1_reg) - 34'(yx1_reg);
            m2_reg  <= 34'($unsigned(sx1_reg)) + 34'($unsigned(sy1_reg))
                     + 34'($unsigned(sz1_reg)) + 34'($unsigned(sw1_reg));
        end
    end

    // stage 3: second-level products, unit test, divisor
    logic               v3_reg;
    logic signed [49:0] sx3_reg, sy3_reg, sz3_reg;
    logic signed [49:0] wx3_reg, wy3_reg, wz3_reg;
    logic signed [49:0] yz3_reg, zy3_reg, zx3_reg, xz3_reg, xy3_reg, yx3_reg;
    logic [qvr_pkg::DIV_W-1:0] d3_reg;
    logic               zero3_reg;

    logic [DFW-1:0]  one_c, m_c, diff_c, dsel_c;
    logic [CMPW-1:0] lhs_c, rhs_c;
    logic            unit_c;
    logic [qvr_pkg::DIV_W-1:0] d_c;

    always_comb begin
        one_c  = DFW'(1) << TWO_F;
        m_c    = DFW'(m2_reg);
        diff_c = (m_c >= one_c) ? (m_c - one_c) : (one_c - m_c);
        lhs_c  = CMPW'(diff_c) << LSH;
        rhs_c  = CMPW'(tol) << RSH;
        unit_c = (lhs_c <= rhs_c);
        dsel_c = unit_c ? one_c : m_c;
        // cap the divisor: any value above the largest magnitude gives zero
        if (CMPW'(dsel_c) > (CMPW'(1) << qvr_pkg::MAG_W)) begin
            d_c = qvr_pkg::DIV_W'(1) << qvr_pkg::MAG_W;
        end else begin
            d_c = qvr_pkg::DIV_W'(dsel_c);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v3_reg <= 1'b0;
        end else if (adv) begin
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            sx3_reg <= ps2_reg * ax;  sy3_reg <= ps2_reg * ay;  sz3_reg <= ps2_reg * az;
            wx3_reg <= px2_reg * aw;  wy3_reg <= py2_reg * aw;  wz3_reg <= pz2_reg * aw;
            yz3_reg <= py2_reg * az;  zy3_reg <= pz2_reg * ay;
            zx3_reg <= pz2_reg * ax;  xz3_reg <= px2_reg * az;
            xy3_reg <= px2_reg * ay;  yx3_reg <= py2_reg * ax;
            d3_reg    <= d_c;
            zero3_reg <= (m2_reg == 34'd0);
        end
    end

    // stage 4: vector part of r, split into sign and magnitude
    logic signed [51:0] rx_c, ry_c, rz_c;
    qvr_pkg::div_item_t x4_reg, y4_reg, z4_reg;

    function automatic qvr_pkg::div_item_t to_item(logic signed [51:0] r,
                                                    logic vld, logic zr,
                                                    logic [qvr_pkg::DIV_W-1:0] d);
        qvr_pkg::div_item_t it;
        logic signed [51:0] a;
        a        = (r < 0) ? -r : r;
        it.valid = vld;
        it.neg   = (r < 0);
        it.zero  = zr;
        it.ovf   = 1'b0;
        it.rem   = a[qvr_pkg::MAG_W-1:0];
        it.d     = d;
        it.q     = '0;
        return it;
    endfunction

    always_comb begin
        rx_c = -52'(sx3_reg) + 52'(wx3_reg) - 52'(yz3_reg) + 52'(zy3_reg);
        ry_c = -52'(sy3_reg) + 52'(wy3_reg) - 52'(zx3_reg) + 52'(xz3_reg);
        rz_c = -52'(sz3_reg) + 52'(wz3_reg) - 52'(xy3_reg) + 52'(yx3_reg);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x4_reg.valid <= 1'b0;
            y4_reg.valid <= 1'b0;
            z4_reg.valid <= 1'b0;
        end else if (adv) begin
            x4_reg <= to_item(rx_c, v3_reg, zero3_reg, d3_reg);
            y4_reg <= to_item(ry_c, v3_reg, zero3_reg, d3_reg);
            z4_reg <= to_item(rz_c, v3_reg, zero3_reg, d3_reg);
        end
    end

    assign out_x = x4_reg;
    assign out_y = y4_reg;
    assign out_z = z4_reg;

endmodule

// File: rtl/qvr_divider.sv
// Pipelined restoring divider: an overflow-detect stage, then one quotient bit per stage.
module qvr_divider (
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               adv,
    input  qvr_pkg::div_item_t in_item,
    output qvr_pkg::div_item_t out_item
);

    localparam int NSTG = qvr_pkg::QUO_W + 1;
    localparam int CW   = qvr_pkg::DIV_W + qvr_pkg::QUO_W;

    qvr_pkg::div_item_t stg_reg [NSTG];
    qvr_pkg::div_item_t stg_next [NSTG];

    genvar j;
    generate
        for (j = 0; j < NSTG; j++) begin : g_stg
            always_comb begin
                qvr_pkg::div_item_t src;
                logic [CW-1:0] dsh;
                src = (j == 0) ? in_item : stg_reg[(j == 0) ? 0 : j - 1];
                stg_next[j] = src;
                if (j == 0) begin
                    // quotient would not fit: saturate later
                    dsh = CW'(src.d) << qvr_pkg::QUO_W;
                    stg_next[j].ovf = (CW'(src.rem) >= dsh);
                end else begin
                    dsh = CW'(src.d) << (qvr_pkg::QUO_W - j);
                    if (!src.ovf && (CW'(src.rem) >= dsh)) begin
                        stg_next[j].rem = src.rem - qvr_pkg::MAG_W'(dsh);
                        stg_next[j].q[qvr_pkg::QUO_W - j] = 1'b1;
                    end
                end
            end

            always_ff @(posedge aclk) begin
                if (!aresetn) begin
                    stg_reg[j].valid <= 1'b0;
                end else if (adv) begin
                    stg_reg[j] <= stg_next[j];
                end
            end
        end
    endgenerate

    assign out_item = stg_reg[NSTG-1];

endmodule

// File: rtl/qvr_checker.sv
// Port-level checks for the rotation core, bound to the top level.
module qvr_checker (
    input logic                              aclk,
    input logic                              aresetn,
    input logic                              m_valid,
    input logic                              m_ready,
    input logic signed [qvr_pkg::COMP_W-1:0] m_rot_x,
    input logic signed [qvr_pkg::COMP_W-1:0] m_rot_y,
    input logic signed [qvr_pkg::COMP_W-1:0] m_rot_z,
    input logic [qvr_pkg::STAT_W-1:0]        m_status
);

    a_zero_out: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && m_status == qvr_pkg::STAT_ZERO) |->
        (m_rot_x == 0 && m_rot_y == 0 && m_rot_z == 0))
        else $error("zero quaternion item with nonzero components");

    a_status_code: assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid |-> (m_status <= qvr_pkg::STAT_ZERO))
        else $error("undefined status code");

    a_reset_idle: assert property (@(posedge aclk)
        !aresetn |=> !m_valid)
        else $error("result valid right after reset");

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid && !m_ready) |=> (m_valid && $stable(m_rot_x) && $stable(m_status)))
        else $error("stalled result item changed");

endmodule

bind quaternion_vector_rotate_core qvr_checker u_qvr_checker (
    .aclk(aclk), .aresetn(aresetn), .m_valid(m_valid), .m_ready(m_ready),
    .m_rot_x(m_rot_x), .m_rot_y(m_rot_y), .m_rot_z(m_rot_z), .m_status(m_status)
);
